// ----- sv/fmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared types, constants and the raised-cosine weight table for the
// modulated fractional delay core.
// ----------------------------------------------------------------------------
package fmd_pkg;

    localparam int SAMPLE_BITS       = 24;
    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int CENTER_DELAY      = 64;
    localparam int MAX_WIDTH         = 64;
    localparam int GAIN_BITS         = 17;
    localparam int SWEEP_BITS        = 15;
    localparam int CFG_DATA_BITS     = 17;
    localparam int ACC_BITS          = 56;
    localparam int MUL_A_BITS        = 48;
    localparam int MUL_B_BITS        = 18;

    localparam logic [SWEEP_BITS:0] SWEEP_MAX = (SWEEP_BITS + 1)'(MAX_WIDTH * 256);
    localparam logic signed [ACC_BITS-1:0] CENTER_Q25 =
        ACC_BITS'(longint'(CENTER_DELAY) <<< 25);
    localparam logic signed [ACC_BITS-1:0] PROD_LIM = ACC_BITS'(64'sd1 <<< 37);
    localparam logic signed [ACC_BITS-1:0] SMAX = ACC_BITS'((64'sd1 <<< 23) - 1);
    localparam logic signed [ACC_BITS-1:0] SMIN = -ACC_BITS'(64'sd1 <<< 23);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] audio_left;
        logic signed [SAMPLE_BITS-1:0] audio_right;
        logic signed [SAMPLE_BITS-1:0] mod_left;
        logic signed [SAMPLE_BITS-1:0] mod_right;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } out_item_t;

    typedef enum logic [1:0] {
        CFG_GAIN  = 2'd0,
        CFG_SWEEP = 2'd1,
        CFG_MODE  = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        BLEND_NEAREST = 2'd0,
        BLEND_LINEAR  = 2'd1,
        BLEND_COSINE  = 2'd2,
        BLEND_CUBIC   = 2'd3
    } blend_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_WRITE, ST_MOD, ST_CLAMP, ST_SPAN, ST_DELAY,
        ST_READ, ST_CAPTURE, ST_COEF, ST_MAC, ST_STORE, ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_CLEAR, OP_LOAD, OP_WRITE, OP_MOD, OP_CLAMP, OP_SPAN,
        OP_DELAY, OP_READ, OP_COEF, OP_MAC, OP_STORE, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       ch;
        logic [1:0] step;
    } cmd_t;

    typedef struct packed {
        logic   clr_last;
        blend_t mode;
        logic   out_busy;
    } status_t;

    typedef logic [16:0] cos_rom_t [256];

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned TAYLOR_DIV [5] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12};

    // Taylor series of cos in Q30, mirrored for the upper half
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        longint unsigned m, x, x2, t, q, v;
        for (int wi = 0; wi < 256; wi++) begin
            m = (wi <= 128) ? 64'(wi) : 64'(256 - wi);
            x = (m * PI_Q30) >> 8;
            x2 = (x * x) >> 30;
            t = Q30_ONE;
            for (int i = 0; i < 5; i++) begin
                t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[i];
            end
            q = ((x2 * t) >> 30) >> 2;
            v = (q + 64'd8192) >> 14;
            rom[wi] = (wi <= 128) ? v[16:0] : 17'(64'd65536 - v);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ----- sv/fmd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fmd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/fmd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmd_ctrl
// Sequencer: clears history after reset, then steps each frame through
// write, delay computation, tap reads and blend for both channels.
// ----------------------------------------------------------------------------
module fmd_ctrl
    import fmd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic       ch_reg, ch_next;
    logic [1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ch_reg    <= 1'b0;
            step_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = step_reg;
        cmd.op     = OP_NOP;
        cmd.ch     = ch_reg;
        cmd.step   = step_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.op     = OP_WRITE;
                ch_next    = 1'b0;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                cmd.op     = OP_MOD;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.op     = OP_CLAMP;
                state_next = ST_SPAN;
            end
            ST_SPAN: begin
                cmd.op     = OP_SPAN;
                state_next = ST_DELAY;
            end
            ST_DELAY: begin
                cmd.op     = OP_DELAY;
                step_next  = 2'd0;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.op    = OP_READ;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = ST_CAPTURE;
                end
            end
            ST_CAPTURE: begin
                // last tap lands this cycle
                step_next = 2'd0;
                case (status.mode)
                    BLEND_NEAREST: state_next = ST_STORE;
                    BLEND_CUBIC:   state_next = ST_COEF;
                    default:       state_next = ST_MAC;
                endcase
            end
            ST_COEF: begin
                cmd.op     = OP_COEF;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.op    = OP_MAC;
                step_next = step_reg + 2'd1;
                if ((status.mode == BLEND_CUBIC && step_reg == 2'd2) ||
                    (status.mode != BLEND_CUBIC && step_reg == 2'd1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.op = OP_STORE;
                if (ch_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    ch_next    = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/fmd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmd_datapath
// History RAM, configuration registers, shared multiply-accumulate unit,
// tap registers and the output word register.
// ----------------------------------------------------------------------------
module fmd_datapath
    import fmd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int D8_BITS = ACC_BITS - 17;
    localparam logic signed [D8_BITS-1:0] DMAX = D8_BITS'((HISTORY_DEPTH - 4) * 256);

    // configuration
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [SWEEP_BITS-1:0] sweep_reg;
    blend_t                mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= GAIN_BITS'(16384);
            sweep_reg <= SWEEP_BITS'(768);
            mode_reg  <= BLEND_LINEAR;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_GAIN:  gain_reg  <= cfg_data;
                CFG_SWEEP: sweep_reg <= cfg_data[SWEEP_BITS-1:0];
                CFG_MODE:  mode_reg  <= blend_t'(cfg_data[1:0]);
                default:   ;
            endcase
        end
    end

    // control registers
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] slot_reg;
    logic          rd_pend_reg;
    logic [1:0]    rd_k_reg;
    logic          m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            slot_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            rd_k_reg     <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.op == OP_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.op == OP_EMIT) begin
                slot_reg <= (slot_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + AW'(1);
            end
            rd_pend_reg <= (cmd.op == OP_READ);
            rd_k_reg    <= cmd.step;
            if (cmd.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clr_last = (clr_addr_reg == AW'(HISTORY_DEPTH - 1));
    assign status.mode     = mode_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

    // history RAM, left sample in the upper half
    in_item_t                      in_reg;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [2*SAMPLE_BITS-1:0]      ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [2*SAMPLE_BITS-1:0]      ram_rdata;
    logic [AW-1:0]                 d_reg;
    logic [7:0]                    w_reg;
    logic [AW:0]                   age;
    logic [AW:0]                   addr_sum;

    assign ram_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_WRITE);
    assign ram_waddr = (cmd.op == OP_CLEAR) ? clr_addr_reg : slot_reg;
    assign ram_wdata = (cmd.op == OP_CLEAR) ? '0 : {in_reg.audio_left, in_reg.audio_right};

    assign age      = {1'b0, d_reg} + (AW + 1)'(cmd.step);
    assign addr_sum = {1'b0, slot_reg} + (AW + 1)'(HISTORY_DEPTH) - age;
    assign ram_raddr = (addr_sum >= (AW + 1)'(HISTORY_DEPTH))
                     ? AW'(addr_sum - (AW + 1)'(HISTORY_DEPTH)) : addr_sum[AW-1:0];

    fmd_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // payload registers
    logic signed [SAMPLE_BITS-1:0] tap_reg [4];
    logic signed [17:0]            c_reg;
    logic signed [26:0]            a0_reg;
    logic signed [27:0]            a1_reg;
    logic signed [24:0]            a2_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg [2];
    out_item_t                     m_data_reg;

    // multiply-accumulate operand selection
    logic signed [MUL_A_BITS-1:0]            mul_a;
    logic signed [MUL_B_BITS-1:0]            mul_b;
    logic signed [ACC_BITS-1:0]              mul_c;
    logic signed [MUL_A_BITS+MUL_B_BITS-1:0] prod;
    logic signed [SAMPLE_BITS-1:0]           mod_sel;
    logic [16:0]                             cos_m;
    logic [SWEEP_BITS:0]                     sweep_c;

    assign mod_sel = cmd.ch ? in_reg.mod_right : in_reg.mod_left;
    assign cos_m   = COS_ROM[w_reg];
    assign sweep_c = ({1'b0, sweep_reg} > SWEEP_MAX) ? SWEEP_MAX : {1'b0, sweep_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        case (cmd.op)
            OP_MOD: begin
                mul_a = MUL_A_BITS'(mod_sel);
                mul_b = MUL_B_BITS'($signed(gain_reg));
            end
            OP_SPAN: begin
                mul_a = MUL_A_BITS'(c_reg);
                mul_b = -$signed({2'b00, sweep_c});
                mul_c = CENTER_Q25;
            end
            OP_MAC: begin
                case (mode_reg)
                    BLEND_CUBIC: begin
                        mul_b = MUL_B_BITS'($signed({1'b0, w_reg}));
                        case (cmd.step)
                            2'd0: begin
                                mul_a = MUL_A_BITS'(a0_reg);
                                mul_c = ACC_BITS'(a1_reg) <<< 8;
                            end
                            2'd1: begin
                                mul_a = acc_reg[MUL_A_BITS-1:0];
                                mul_c = ACC_BITS'(a2_reg) <<< 16;
                            end
                            default: begin
                                mul_a = acc_reg[MUL_A_BITS-1:0];
                                mul_c = (ACC_BITS'(tap_reg[1]) <<< 24)
                                      + ACC_BITS'(64'sd1 <<< 23);
                            end
                        endcase
                    end
                    BLEND_COSINE: begin
                        if (cmd.step == 2'd0) begin
                            mul_a = MUL_A_BITS'(tap_reg[1]);
                            mul_b = MUL_B_BITS'(18'sd65536 - $signed({1'b0, cos_m}));
                            mul_c = ACC_BITS'(32768);
                        end else begin
                            mul_a = MUL_A_BITS'(tap_reg[2]);
                            mul_b = MUL_B_BITS'($signed({1'b0, cos_m}));
                            mul_c = acc_reg;
                        end
                    end
                    default: begin
                        if (cmd.step == 2'd0) begin
                            mul_a = MUL_A_BITS'(tap_reg[1]);
                            mul_b = MUL_B_BITS'(18'sd256 - $signed({10'd0, w_reg}));
                            mul_c = ACC_BITS'(128);
                        end else begin
                            mul_a = MUL_A_BITS'(tap_reg[2]);
                            mul_b = MUL_B_BITS'($signed({1'b0, w_reg}));
                            mul_c = acc_reg;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // clamp of the scaled modulation and the delay
    logic signed [17:0]          c_next;
    logic signed [ACC_BITS-1:0]  acc_shr;
    logic signed [D8_BITS-1:0]   d8;
    logic signed [D8_BITS-1:0]   d8_c;
    logic signed [ACC_BITS-1:0]  r_full;
    logic signed [SAMPLE_BITS-1:0] r_sat;

    assign acc_shr = acc_reg >>> 21;
    always_comb begin
        if (acc_reg > PROD_LIM) begin
            c_next = 18'sd65536;
        end else if (acc_reg < -PROD_LIM) begin
            c_next = -18'sd65536;
        end else begin
            c_next = acc_shr[17:0];
        end
    end

    assign d8 = D8_BITS'(acc_reg >>> 17);
    assign d8_c = (d8 < 0) ? '0 : ((d8 > DMAX) ? DMAX : d8);

    always_comb begin
        case (mode_reg)
            BLEND_LINEAR: r_full = acc_reg >>> 8;
            BLEND_COSINE: r_full = acc_reg >>> 16;
            BLEND_CUBIC:  r_full = acc_reg >>> 24;
            default:      r_full = (w_reg < 8'd128) ? ACC_BITS'(tap_reg[1])
                                                    : ACC_BITS'(tap_reg[2]);
        endcase
        if (r_full > SMAX) begin
            r_sat = SMAX[SAMPLE_BITS-1:0];
        end else if (r_full < SMIN) begin
            r_sat = SMIN[SAMPLE_BITS-1:0];
        end else begin
            r_sat = r_full[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            in_reg <= s_data;
        end
        if (rd_pend_reg) begin
            tap_reg[rd_k_reg] <= cmd.ch ? ram_rdata[SAMPLE_BITS-1:0]
                                        : ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (cmd.op == OP_MOD || cmd.op == OP_SPAN || cmd.op == OP_MAC) begin
            acc_reg <= prod[ACC_BITS-1:0] + mul_c;
        end
        if (cmd.op == OP_CLAMP) begin
            c_reg <= c_next;
        end
        if (cmd.op == OP_DELAY) begin
            d_reg <= d8_c[AW+7:8];
            w_reg <= d8_c[7:0];
        end
        if (cmd.op == OP_COEF) begin
            a0_reg <= 27'(tap_reg[3]) - 27'(tap_reg[2]) - 27'(tap_reg[0]) + 27'(tap_reg[1]);
            a1_reg <= 28'(tap_reg[0]) - 28'(tap_reg[1]) - 28'(tap_reg[3])
                    + 28'(tap_reg[2]) + 28'(tap_reg[0]) - 28'(tap_reg[1]);
            a2_reg <= 25'(tap_reg[2]) - 25'(tap_reg[0]);
        end
        if (cmd.op == OP_STORE) begin
            res_reg[cmd.ch] <= r_sat;
        end
        if (cmd.op == OP_EMIT) begin
            m_data_reg.out_left  <= res_reg[0];
            m_data_reg.out_right <= res_reg[1];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sv/modulated_fractional_delay_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulated_fractional_delay_core
// Stereo vibrato: writes each frame into history, reads four taps around a
// modulated delay per channel and blends them (nearest/linear/cosine/cubic).
//
//   channel  ports                          direction  word
//   s_       s_valid s_ready s_data         in         in_item_t
//   m_       m_valid m_ready m_data         out        out_item_t
//   cfg_     cfg_we cfg_index cfg_data      in         register write
//
// One shared multiply-accumulate unit and one RAM read port serve both
// channels of a frame, with eight tap reads and up to three blend steps per
// channel.
// After reset a clearing pass zeroes the whole history;
// s_ready stays low during it.
// A new frame is accepted while the previous result waits on m_ready; the
// result of that frame holds in the sequencer until the output is free.
// ----------------------------------------------------------------------------
module modulated_fractional_delay_core
    import fmd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    fmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fmd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // a frame in flight blocks the next accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a word while a frame was in flight");

    // never overwrite a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |-> !(m_valid && !m_ready))
        else $error("result overwritten before it was taken");

    // clearing pass follows reset
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or valid right after reset");

    // history is written only while clearing or for an accepted frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_WRITE |-> $past(s_valid && s_ready))
        else $error("history write without an accepted frame");

endmodule
